// ----- design/dprc_pkg.sv -----
// Types and constants shared by the DMA page-run coalescer modules.
package dprc_pkg;

   localparam int PAGE_SHIFT_DEF = 13;
   localparam int FRAME_BITS_DEF = 28;

   localparam int REQ_DATA_W = 160;
   localparam int RSP_DATA_W = 112;
   localparam int CSR_ADDR_W = 4;
   localparam int CSR_DATA_W = 64;

   localparam logic REG_BYPASS_BASE     = 1'b0;
   localparam logic REG_NONCACHE_PREFIX = 1'b1;

   localparam int QUEUE_DEPTH = 4;
   localparam int QUEUE_AW    = 2;
   localparam int QUEUE_CW    = 3;

   typedef struct packed {
      logic        first_page;
      logic        last_page;
      logic [27:0] frame_number;
      logic [12:0] start_offset;
      logic [31:0] transfer_size;
      logic        is_memory;
      logic [63:0] count_max;
      logic [15:0] max_segments;
   } item_type;

   typedef struct packed {
      logic [63:0] address;
      logic [31:0] size;
      logic        last_seg;
      logic        too_big;
      logic [15:0] count;
   } seg_type;

   typedef struct packed {
      logic [1:0] num;
      seg_type    first_seg;
      seg_type    second_seg;
   } push_type;

endpackage

// ----- design/dprc_front.sv -----
// Front end: input register with address precompute, then the run-merging state engine.
module dprc_front import dprc_pkg::*; #(
   parameter int PAGE_SHIFT = PAGE_SHIFT_DEF,
   parameter int FRAME_BITS = FRAME_BITS_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  logic [63:0] bypass_base,
   input  logic [63:0] noncache_prefix,
   input  logic        req_valid,
   output logic        req_ready,
   input  item_type    req_item,
   input  logic        queue_room,
   output push_type    push
);

   localparam logic [32:0] PAGE_BYTES = 33'(64'(1) << PAGE_SHIFT);

   logic                  a_valid_ff;
   item_type              a_item_ff;
   logic [63:0]           a_sum_ff;
   logic [PAGE_SHIFT-1:0] off_w;
   logic [FRAME_BITS-1:0] frame_w;
   logic [63:0]           sum_in;

   logic [63:0]           open_address_ff, open_address_in;
   logic [32:0]           open_bytes_ff, open_bytes_in;
   logic [31:0]           bytes_left_ff, bytes_left_in;
   logic [FRAME_BITS-1:0] previous_frame_ff, previous_frame_in;
   logic [15:0]           segments_made_ff, segments_made_in;
   logic [63:0]           held_count_max_ff, held_count_max_in;
   logic [15:0]           held_segment_limit_ff, held_segment_limit_in;
   logic                  io_space_ff, io_space_in;
   logic                  transfer_active_ff, transfer_active_in;

   logic                  commit;
   logic                  io_now;
   logic [63:0]           item_addr;
   logic [FRAME_BITS-1:0] b_frame;
   logic [PAGE_SHIFT-1:0] b_offset;
   logic                  gap;
   logic                  full;
   logic                  stop;
   logic [32:0]           bytes_base;
   seg_type               fin_seg;

   assign commit    = a_valid_ff && queue_room;
   assign req_ready = !a_valid_ff || queue_room;

   always_comb begin
      off_w   = req_item.first_page ? PAGE_SHIFT'(req_item.start_offset) : '0;
      frame_w = FRAME_BITS'(req_item.frame_number);
      sum_in  = bypass_base + ((64'(frame_w) << PAGE_SHIFT) + 64'(off_w));
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff <= 1'b0;
      end else if (req_ready) begin
         a_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         a_item_ff <= req_item;
         a_sum_ff  <= sum_in;
      end
   end

   assign b_frame   = FRAME_BITS'(a_item_ff.frame_number);
   assign b_offset  = PAGE_SHIFT'(a_item_ff.start_offset);
   assign io_now    = a_item_ff.first_page ? ~a_item_ff.is_memory : io_space_ff;
   assign item_addr = a_sum_ff | (io_now ? noncache_prefix : 64'd0);
   assign gap       = b_frame != (previous_frame_ff + 1'b1);
   assign full      = 64'(34'(open_bytes_ff) + 34'(PAGE_BYTES)) > held_count_max_ff;

   always_comb begin
      open_address_in       = open_address_ff;
      open_bytes_in         = open_bytes_ff;
      bytes_left_in         = bytes_left_ff;
      previous_frame_in     = previous_frame_ff;
      segments_made_in      = segments_made_ff;
      held_count_max_in     = held_count_max_ff;
      held_segment_limit_in = held_segment_limit_ff;
      io_space_in           = io_space_ff;
      transfer_active_in    = transfer_active_ff;
      push                  = '0;
      stop                  = 1'b0;
      bytes_base            = open_bytes_ff;
      fin_seg               = '0;
      if (commit) begin
         if (a_item_ff.first_page) begin
            transfer_active_in    = 1'b0;
            held_segment_limit_in = a_item_ff.max_segments;
            held_count_max_in     = (a_item_ff.count_max == 64'd0) ? '1 : a_item_ff.count_max;
            if (a_item_ff.max_segments == 16'd0) begin
               push.num               = 2'd1;
               push.first_seg.too_big = 1'b1;
               stop                   = 1'b1;
            end else begin
               io_space_in        = ~a_item_ff.is_memory;
               bytes_left_in      = a_item_ff.transfer_size;
               open_address_in    = item_addr;
               open_bytes_in      = PAGE_BYTES - 33'(b_offset);
               previous_frame_in  = b_frame;
               segments_made_in   = 16'd1;
               transfer_active_in = 1'b1;
            end
         end else if (!transfer_active_ff) begin
            stop = 1'b1;
         end else if ({1'b0, bytes_left_ff} > open_bytes_ff) begin
            if (gap || full) begin
               if (segments_made_ff >= held_segment_limit_ff) begin
                  push.num               = 2'd1;
                  push.first_seg.too_big = 1'b1;
                  push.first_seg.count   = segments_made_ff;
                  transfer_active_in     = 1'b0;
                  stop                   = 1'b1;
               end else begin
                  push.num                = 2'd1;
                  push.first_seg.address  = open_address_ff;
                  push.first_seg.size     = open_bytes_ff[31:0];
                  push.first_seg.count    = segments_made_ff;
                  bytes_left_in           = bytes_left_ff - open_bytes_ff[31:0];
                  bytes_base              = 33'd0;
                  segments_made_in        = segments_made_ff + 16'd1;
                  open_address_in         = item_addr;
               end
            end
            if (!stop) begin
               open_bytes_in     = bytes_base + PAGE_BYTES;
               previous_frame_in = b_frame;
            end
         end
         if (!stop && a_item_ff.last_page) begin
            fin_seg.address    = open_address_in;
            fin_seg.size       = bytes_left_in;
            fin_seg.last_seg   = 1'b1;
            fin_seg.count      = segments_made_in;
            transfer_active_in = 1'b0;
            if (push.num == 2'd0) begin
               push.first_seg = fin_seg;
            end else begin
               push.second_seg = fin_seg;
            end
            push.num = push.num + 2'd1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         open_address_ff       <= '0;
         open_bytes_ff         <= '0;
         bytes_left_ff         <= '0;
         previous_frame_ff     <= '0;
         segments_made_ff      <= '0;
         held_count_max_ff     <= '1;
         held_segment_limit_ff <= '0;
         io_space_ff           <= 1'b0;
         transfer_active_ff    <= 1'b0;
      end else begin
         open_address_ff       <= open_address_in;
         open_bytes_ff         <= open_bytes_in;
         bytes_left_ff         <= bytes_left_in;
         previous_frame_ff     <= previous_frame_in;
         segments_made_ff      <= segments_made_in;
         held_count_max_ff     <= held_count_max_in;
         held_segment_limit_ff <= held_segment_limit_in;
         io_space_ff           <= io_space_in;
         transfer_active_ff    <= transfer_active_in;
      end
   end

endmodule

// ----- design/dprc_queue.sv -----
// Segment queue between the front end and the output stage; takes up to two segments a cycle.
module dprc_queue import dprc_pkg::*; (
   input  logic     clock,
   input  logic     reset,
   input  push_type push,
   input  logic     pop,
   output seg_type  head,
   output logic     not_empty,
   output logic     room
);

   seg_type               entry_ff [QUEUE_DEPTH];
   logic [QUEUE_AW-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [QUEUE_AW-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [QUEUE_CW-1:0]   count_ff, count_in;
   logic [QUEUE_AW-1:0]   wr_next;

   assign wr_next   = wr_ptr_ff + 1'b1;
   assign wr_ptr_in = wr_ptr_ff + QUEUE_AW'(push.num);
   assign rd_ptr_in = rd_ptr_ff + QUEUE_AW'(pop);
   assign count_in  = count_ff + QUEUE_CW'(push.num) - QUEUE_CW'(pop);
   assign head      = entry_ff[rd_ptr_ff];
   assign not_empty = count_ff != '0;
   assign room      = count_ff <= QUEUE_CW'(QUEUE_DEPTH - 2);

   always_ff @(posedge clock) begin
      if (push.num != 2'd0) begin
         entry_ff[wr_ptr_ff] <= push.first_seg;
      end
      if (push.num == 2'd2) begin
         entry_ff[wr_next] <= push.second_seg;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule

// ----- design/dprc_back.sv -----
// Output stage: registered result slot fed from the segment queue.
module dprc_back import dprc_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  seg_type head,
   input  logic    not_empty,
   output logic    pop,
   output logic    rsp_valid,
   input  logic    rsp_ready,
   output seg_type rsp_seg
);

   logic    rsp_valid_ff, rsp_valid_in;
   seg_type rsp_seg_ff;

   assign pop          = not_empty && (!rsp_valid_ff || rsp_ready);
   assign rsp_valid_in = pop || (rsp_valid_ff && !rsp_ready);
   assign rsp_valid    = rsp_valid_ff;
   assign rsp_seg      = rsp_seg_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (pop) begin
         rsp_seg_ff <= head;
      end
   end

endmodule

// ----- design/dma_page_run_coalescer_core.sv -----
// DMA page-run coalescer: top level with the register port and stream channels.
//
// Request channel: one page frame per transfer; the item with req_tuser (first page)
// set also brings offset, size, memory/IO kind and the two limits; req_tlast marks
// the last page of the list. Runs of consecutive frames merge into segments.
// Response channel: one segment per transfer with bus address, size and number;
// rsp_tlast marks the final segment, rsp_tuser flags an exceeded or zero segment
// limit, after which the list is dropped until the next first page.
// The register port holds the bypass window base and the IO non-cache prefix;
// write it only while no page is in flight.
// A page passes the input register, the segment queue and the output slot before its
// segment is offered; a page that closes a run and ends the list gives two segments,
// which the response channel moves one after the other.
// Throughput: one page per cycle while the queue has room; the response channel moves
// one segment per cycle while rsp_tready is high.
// Reset clears all run state and both registers; the block is ready at once.
// When the receiver stalls, results build up in a four-entry queue; the run state
// holds once fewer than two entries are free, and the request side stops after
// one more page.
module dma_page_run_coalescer_core import dprc_pkg::*; #(
   parameter int PAGE_SHIFT = PAGE_SHIFT_DEF,
   parameter int FRAME_BITS = FRAME_BITS_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  csr_psel,
   input  logic                  csr_penable,
   input  logic                  csr_pwrite,
   input  logic [CSR_ADDR_W-1:0] csr_paddr,
   input  logic [CSR_DATA_W-1:0] csr_pwdata,
   output logic [CSR_DATA_W-1:0] csr_prdata,
   output logic                  csr_pready,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   // frame_number, start_offset, transfer_size, is_memory, count_max, max_segments
   input  logic [REQ_DATA_W-1:0] req_tdata,
   // first_page
   input  logic                  req_tuser,
   input  logic                  req_tlast,
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   // segment_address, segment_size, segment_count
   output logic [RSP_DATA_W-1:0] rsp_tdata,
   // too_big
   output logic                  rsp_tuser,
   output logic                  rsp_tlast
);

   logic [63:0] bypass_base_ff;
   logic [63:0] noncache_prefix_ff;
   logic        csr_write;
   item_type    req_item;
   push_type    push;
   logic        queue_room;
   logic        pop;
   logic        not_empty;
   seg_type     head;
   seg_type     rsp_seg;

   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;

   always_ff @(posedge clock) begin
      if (reset) begin
         bypass_base_ff     <= '0;
         noncache_prefix_ff <= '0;
      end else if (csr_write) begin
         unique case (csr_paddr[3])
            REG_BYPASS_BASE:     bypass_base_ff     <= csr_pwdata;
            REG_NONCACHE_PREFIX: noncache_prefix_ff <= csr_pwdata;
            default: ;
         endcase
      end
   end

   always_comb begin
      unique case (csr_paddr[3])
         REG_BYPASS_BASE:     csr_prdata = bypass_base_ff;
         REG_NONCACHE_PREFIX: csr_prdata = noncache_prefix_ff;
         default:             csr_prdata = '0;
      endcase
   end

   always_comb begin
      req_item.first_page    = req_tuser;
      req_item.last_page     = req_tlast;
      req_item.frame_number  = req_tdata[27:0];
      req_item.start_offset  = req_tdata[40:28];
      req_item.transfer_size = req_tdata[72:41];
      req_item.is_memory     = req_tdata[73];
      req_item.count_max     = req_tdata[137:74];
      req_item.max_segments  = req_tdata[153:138];
   end

   dprc_front #(
      .PAGE_SHIFT (PAGE_SHIFT),
      .FRAME_BITS (FRAME_BITS)
   ) u_front (
      .clock           (clock),
      .reset           (reset),
      .bypass_base     (bypass_base_ff),
      .noncache_prefix (noncache_prefix_ff),
      .req_valid       (req_tvalid),
      .req_ready       (req_tready),
      .req_item        (req_item),
      .queue_room      (queue_room),
      .push            (push)
   );

   dprc_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .pop       (pop),
      .head      (head),
      .not_empty (not_empty),
      .room      (queue_room)
   );

   dprc_back u_back (
      .clock     (clock),
      .reset     (reset),
      .head      (head),
      .not_empty (not_empty),
      .pop       (pop),
      .rsp_valid (rsp_tvalid),
      .rsp_ready (rsp_tready),
      .rsp_seg   (rsp_seg)
   );

   assign rsp_tdata = {rsp_seg.count, rsp_seg.size, rsp_seg.address};
   assign rsp_tuser = rsp_seg.too_big;
   assign rsp_tlast = rsp_seg.last_seg;

endmodule

// ----- dv/dma_page_run_coalescer_core_tb.sv -----
// Self-checking testbench for the DMA page-run coalescer core.
module dma_page_run_coalescer_core_tb;
   import dprc_pkg::*;

   localparam longint unsigned PAGE_BYTES = 64'd1 << PAGE_SHIFT_DEF;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  csr_psel = 1'b0;
   logic                  csr_penable = 1'b0;
   logic                  csr_pwrite = 1'b0;
   logic [CSR_ADDR_W-1:0] csr_paddr = '0;
   logic [CSR_DATA_W-1:0] csr_pwdata = '0;
   logic [CSR_DATA_W-1:0] csr_prdata;
   logic                  csr_pready;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   // frame_number, start_offset, transfer_size, is_memory, count_max, max_segments
   logic [REQ_DATA_W-1:0] req_tdata = '0;
   // first_page
   logic                  req_tuser = 1'b0;
   logic                  req_tlast = 1'b0;
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b1;
   // segment_address, segment_size, segment_count
   logic [RSP_DATA_W-1:0] rsp_tdata;
   // too_big
   logic                  rsp_tuser;
   logic                  rsp_tlast;

   dma_page_run_coalescer_core dut (.*);

   always #1 clock = ~clock;

   // predictor state
   bit [63:0] window_base, io_prefix;
   bit [63:0] run_address, run_bytes, byte_cap;
   bit [31:0] bytes_remaining;
   bit [27:0] last_frame;
   bit [15:0] segment_number, segment_cap;
   bit        io_transfer, in_transfer;

   seg_type expected_segments[$];
   int      mismatches = 0;
   int      pages_sent = 0;
   int      send_odds = 0;
   int      stall_odds = 0;
   int      stall_left = 0;

   task automatic report_mismatch(input string what, input logic [63:0] want,
                                  input logic [63:0] got);
      $display("mismatch %s: expected %h got %h at %0t", what, want, got, $realtime);
      mismatches++;
   endtask

   function automatic bit [63:0] bus_address(input bit [27:0] frame,
                                             input bit [12:0] offset);
      bit [63:0] a;
      a = window_base + ((64'(frame) << PAGE_SHIFT_DEF) + 64'(offset));
      return io_transfer ? (a | io_prefix) : a;
   endfunction

   task automatic push_segment(input bit [63:0] addr, input bit [63:0] size,
                               input bit fin, input bit big, input bit [15:0] num);
      seg_type s;
      s.address  = addr;
      s.size     = size[31:0];
      s.last_seg = fin;
      s.too_big  = big;
      s.count    = num;
      expected_segments.push_back(s);
   endtask

   task automatic coalesce_page(input item_type p);
      bit gap, full;
      bit [12:0] offset;
      if (p.first_page) begin
         offset = p.start_offset & 13'(PAGE_BYTES - 1);
         in_transfer = 1'b0;
         segment_cap = p.max_segments;
         byte_cap = (p.count_max == 0) ? 64'hffff_ffff_ffff_ffff : p.count_max;
         if (segment_cap == 0) begin
            push_segment(64'd0, 64'd0, 1'b0, 1'b1, 16'd0);
            return;
         end
         io_transfer = !p.is_memory;
         bytes_remaining = p.transfer_size;
         run_address = bus_address(p.frame_number, offset);
         run_bytes = PAGE_BYTES - 64'(offset);
         last_frame = p.frame_number;
         segment_number = 16'd1;
         in_transfer = 1'b1;
      end else begin
         if (!in_transfer) return;
         if (64'(bytes_remaining) > run_bytes) begin
            gap = p.frame_number != 28'(last_frame + 28'd1);
            full = run_bytes + PAGE_BYTES > byte_cap;
            if (gap || full) begin
               if (segment_number >= segment_cap) begin
                  push_segment(64'd0, 64'd0, 1'b0, 1'b1, segment_number);
                  in_transfer = 1'b0;
                  return;
               end
               push_segment(run_address, run_bytes, 1'b0, 1'b0, segment_number);
               bytes_remaining = bytes_remaining - run_bytes[31:0];
               run_bytes = 0;
               segment_number = segment_number + 16'd1;
               run_address = bus_address(p.frame_number, 13'd0);
            end
            run_bytes = run_bytes + PAGE_BYTES;
            last_frame = p.frame_number;
         end
      end
      if (p.last_page) begin
         push_segment(run_address, 64'(bytes_remaining), 1'b1, 1'b0, segment_number);
         in_transfer = 1'b0;
      end
   endtask

   // predict on every accepted page
   always @(posedge clock) begin
      item_type p;
      if (!reset && req_tvalid && req_tready) begin
         p.first_page    = req_tuser;
         p.last_page     = req_tlast;
         p.frame_number  = req_tdata[27:0];
         p.start_offset  = req_tdata[40:28];
         p.transfer_size = req_tdata[72:41];
         p.is_memory     = req_tdata[73];
         p.count_max     = req_tdata[137:74];
         p.max_segments  = req_tdata[153:138];
         coalesce_page(p);
      end
   end

   // check every accepted segment against the oldest prediction
   always @(posedge clock) begin
      seg_type s;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (expected_segments.size() == 0) begin
            report_mismatch("unexpected segment", '0, rsp_tdata[63:0]);
         end else begin
            s = expected_segments.pop_front();
            if (rsp_tdata[63:0] !== s.address)
               report_mismatch("segment_address", s.address, rsp_tdata[63:0]);
            if (rsp_tdata[95:64] !== s.size)
               report_mismatch("segment_size", 64'(s.size), 64'(rsp_tdata[95:64]));
            if (rsp_tlast !== s.last_seg)
               report_mismatch("final_segment", 64'(s.last_seg), 64'(rsp_tlast));
            if (rsp_tuser !== s.too_big)
               report_mismatch("too_big", 64'(s.too_big), 64'(rsp_tuser));
            if (rsp_tdata[111:96] !== s.count)
               report_mismatch("segment_count", 64'(s.count), 64'(rsp_tdata[111:96]));
         end
      end
   end

   // receiver back-pressure in bursts
   always @(negedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b1;
      end else if (stall_left > 0) begin
         stall_left--;
         rsp_tready <= 1'b0;
      end else if (stall_odds != 0 && $urandom_range(1, stall_odds) == 1) begin
         stall_left = $urandom_range(0, 15);
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= 1'b1;
      end
   end

   task automatic send_page(input item_type p);
      int gap;
      gap = 0;
      if (send_odds != 0 && $urandom_range(1, send_odds) == 1) gap = $urandom_range(1, 16);
      if (gap > 0) begin
         @(negedge clock);
         req_tvalid <= 1'b0;
         repeat (gap - 1) @(negedge clock);
      end
      @(negedge clock);
      req_tvalid <= 1'b1;
      req_tuser  <= p.first_page;
      req_tlast  <= p.last_page;
      req_tdata  <= {6'd0, p.max_segments, p.count_max, p.is_memory, p.transfer_size,
                     p.start_offset, p.frame_number};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      pages_sent++;
   endtask

   task automatic hold_requests();
      @(negedge clock);
      req_tvalid <= 1'b0;
   endtask

   task automatic drain_segments();
      while (expected_segments.size() != 0) @(posedge clock);
      repeat (8) @(posedge clock);
   endtask

   task automatic csr_write(input logic index, input logic [63:0] value);
      @(negedge clock);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= {index, 3'b000};
      csr_pwdata  <= value;
      @(negedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      while (!csr_pready) @(posedge clock);
      if (index == REG_BYPASS_BASE) window_base = value;
      else io_prefix = value;
      @(negedge clock);
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      @(negedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      while (!csr_pready) @(posedge clock);
      if (csr_prdata !== value) report_mismatch("register readback", value, csr_prdata);
      @(negedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
   endtask

   task automatic set_window(input logic [63:0] base, input logic [63:0] prefix);
      hold_requests();
      drain_segments();
      csr_write(REG_BYPASS_BASE, base);
      csr_write(REG_NONCACHE_PREFIX, prefix);
   endtask

   function automatic item_type junk_page();
      item_type p;
      p.first_page    = 1'b0;
      p.last_page     = 1'b0;
      p.frame_number  = 28'($urandom);
      p.start_offset  = 13'($urandom);
      p.transfer_size = $urandom;
      p.is_memory     = 1'($urandom);
      p.count_max     = {$urandom, $urandom};
      p.max_segments  = 16'($urandom);
      return p;
   endfunction

   function automatic item_type head_page(input bit [27:0] frame, input bit [12:0] offset,
                                          input bit [31:0] size, input bit mem,
                                          input bit [63:0] cap, input bit [15:0] segs,
                                          input bit fin);
      item_type p;
      p.first_page    = 1'b1;
      p.last_page     = fin;
      p.frame_number  = frame;
      p.start_offset  = offset;
      p.transfer_size = size;
      p.is_memory     = mem;
      p.count_max     = cap;
      p.max_segments  = segs;
      return p;
   endfunction

   task automatic send_frame(input bit [27:0] frame, input bit fin);
      item_type p;
      p = junk_page();
      p.frame_number = frame;
      p.last_page = fin;
      send_page(p);
   endtask

   task automatic test_single_page();
      set_window(64'd0, 64'd0);
      send_page(head_page(28'd5, 13'd100, 32'd500, 1'b1, 64'd0, 16'd1, 1'b1));
      send_page(head_page(28'hfff_ffff, 13'h1fff, 32'hffff_ffff, 1'b0,
                          64'hffff_ffff_ffff_ffff, 16'hffff, 1'b1));
   endtask

   task automatic test_zero_limit();
      send_page(head_page(28'd7, 13'd0, 32'd8192, 1'b1, 64'd0, 16'd0, 1'b1));
      send_frame(28'd8, 1'b1);
   endtask

   task automatic test_limit_exceeded();
      send_page(head_page(28'd10, 13'd0, 32'd24576, 1'b1, 64'd0, 16'd1, 1'b0));
      send_frame(28'd20, 1'b0);
      send_frame(28'd21, 1'b1);
   endtask

   task automatic test_count_limit();
      send_page(head_page(28'd30, 13'd0, 32'd32768, 1'b1, 64'd16384, 16'd4, 1'b0));
      send_frame(28'd31, 1'b0);
      send_frame(28'd32, 1'b0);
      send_frame(28'd33, 1'b1);
   endtask

   task automatic test_frame_wrap();
      set_window(64'hffff_ffff_ffff_ffff, 64'h8000_0000_0000_0001);
      send_page(head_page(28'hfff_ffff, 13'd8191, 32'd9000, 1'b0, 64'd0, 16'd2, 1'b0));
      send_frame(28'd0, 1'b0);
      send_frame(28'd1, 1'b1);
      send_page(head_page(28'd40, 13'd0, 32'd100, 1'b0, 64'd0, 16'd3, 1'b0));
      send_frame(28'd41, 1'b0);
      send_frame(28'd90, 1'b0);
      send_frame(28'd91, 1'b1);
   endtask

   task automatic test_idle_and_restart();
      set_window(64'h0123_4567_89ab_cdef, 64'hffff_ffff_ffff_ffff);
      send_frame(28'd50, 1'b1);
      send_page(head_page(28'd60, 13'd16, 32'd20000, 1'b0, 64'd0, 16'd5, 1'b0));
      send_frame(28'd61, 1'b0);
      send_page(head_page(28'd70, 13'd0, 32'd16384, 1'b1, 64'd0, 16'd5, 1'b0));
      send_frame(28'd72, 1'b1);
   endtask

   task automatic random_transfer();
      item_type p;
      longint unsigned span;
      int pages, k;
      bit [27:0] frame;
      bit drop_tail;
      p = junk_page();
      p.first_page = 1'b1;
      case ($urandom_range(0, 3))
         0: p.start_offset = 13'd0;
         1: p.start_offset = 13'h1fff;
         default: p.start_offset = 13'($urandom);
      endcase
      case ($urandom_range(0, 15))
         0: p.transfer_size = 32'd0;
         1: p.transfer_size = $urandom;
         default: p.transfer_size = $urandom_range(1, 6 * 8192);
      endcase
      case ($urandom_range(0, 4))
         0, 1: p.count_max = 64'd0;
         2: p.count_max = PAGE_BYTES * $urandom_range(1, 3);
         3: p.count_max = 64'($urandom_range(1, 30000));
         default: p.count_max = {$urandom, $urandom};
      endcase
      case ($urandom_range(0, 15))
         0: p.max_segments = 16'd0;
         1: p.max_segments = 16'($urandom);
         default: p.max_segments = 16'($urandom_range(1, 4));
      endcase
      frame = ($urandom_range(0, 7) == 0) ? 28'hfff_ffff - 28'($urandom_range(0, 3))
                                          : 28'($urandom);
      p.frame_number = frame;
      span = 64'(p.start_offset) + 64'(p.transfer_size) + PAGE_BYTES - 1;
      pages = (span / PAGE_BYTES > 8) ? $urandom_range(1, 8) : int'(span / PAGE_BYTES);
      if ($urandom_range(0, 3) == 0) pages += $urandom_range(1, 2);
      else if ($urandom_range(0, 5) == 0) pages -= 1;
      if (pages < 1) pages = 1;
      drop_tail = $urandom_range(0, 9) == 0;
      p.last_page = (pages == 1) && !drop_tail;
      send_page(p);
      for (k = 1; k < pages; k++) begin
         frame = ($urandom_range(0, 3) == 0) ? 28'($urandom) : frame + 28'd1;
         send_frame(frame, (k == pages - 1) && !drop_tail);
      end
      if ($urandom_range(0, 11) == 0) send_frame(28'($urandom), 1'($urandom));
   endtask

   task automatic test_random_transfers();
      int phase;
      logic [63:0] base, prefix;
      for (phase = 0; phase < 4; phase++) begin
         case (phase)
            0: begin base = 64'd0; prefix = 64'hffff_ffff_ffff_ffff; end
            1: begin base = 64'hffff_ffff_ffff_ffff; prefix = 64'd0; end
            default: begin base = {$urandom, $urandom}; prefix = {$urandom, $urandom}; end
         endcase
         set_window(base, prefix);
         while (pages_sent < 25 + 125 * (phase + 1)) begin
            if (phase == 3 && pages_sent > 420) begin
               send_odds = 0;
               stall_odds = 0;
            end else begin
               send_odds = $urandom_range(0, 2) * 3;
               stall_odds = $urandom_range(0, 2) * 3;
            end
            random_transfer();
         end
      end
   endtask

   initial begin
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      test_single_page();
      test_zero_limit();
      test_limit_exceeded();
      test_count_limit();
      test_frame_wrap();
      test_idle_and_restart();
      test_random_transfers();
      hold_requests();
      drain_segments();
      repeat (10) @(posedge clock);
      if (mismatches == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end

   initial begin
      #2000000;
      $display("Some tests failed");
      $finish;
   end

endmodule
